// File: hw/rtl/pbg_pkg.sv
// ----------------------------------------------------------------------------
// pbg_pkg
// Types, constants and the control store of the brightness and gamma block.
// ----------------------------------------------------------------------------
package pbg_pkg;

   localparam int CHAN_W = 8;
   localparam int BRIGHT_W = 7;

   localparam logic [BRIGHT_W-1:0] BRIGHT_MAX = 7'd100;
   localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 7'd30;

   // floor(x / 100) = (x * 5243) >> 19 for every x below 43690.
   localparam logic [16:0] RECIP_100 = 17'd5243;
   localparam int SHIFT_100 = 19;
   // floor(x / 255) = (x * 65794) >> 24 for every x up to 255 * 255.
   localparam logic [16:0] RECIP_255 = 17'd65794;
   localparam int SHIFT_255 = 24;

   typedef logic [1:0] pc_type;
   typedef logic [1:0] chan_type;

   localparam chan_type CHAN_RED = 2'd0;
   localparam chan_type CHAN_GREEN = 2'd1;
   localparam chan_type CHAN_LAST = 2'd2;

   typedef enum logic [1:0] {
      OPA_CHAN,
      OPA_PROD,
      OPA_QUOT
   } opa_type;

   typedef enum logic [1:0] {
      OPB_BRIGHT,
      OPB_RECIP100,
      OPB_QUOT,
      OPB_RECIP255
   } opb_type;

   typedef enum logic {
      DEST_PROD,
      DEST_RESULT
   } dest_type;

   typedef struct packed {
      opa_type  opa;
      opb_type  opb;
      dest_type dest;
      logic     jump_chan;
      pc_type   target;
   } ucode_word_type;

   typedef struct packed {
      logic     en;
      opa_type  opa;
      opb_type  opb;
      dest_type dest;
      chan_type chan;
      logic     finish;
   } ctl_type;

   // Four steps per channel; the last step loops back for the next channel.
   function automatic ucode_word_type ucode_rom(input pc_type pc);
      ucode_word_type word;
      unique case (pc)
         2'd0: word = '{OPA_CHAN, OPB_BRIGHT,   DEST_PROD,   1'b0, 2'd0};
         2'd1: word = '{OPA_PROD, OPB_RECIP100, DEST_PROD,   1'b0, 2'd0};
         2'd2: word = '{OPA_QUOT, OPB_QUOT,     DEST_PROD,   1'b0, 2'd0};
         2'd3: word = '{OPA_PROD, OPB_RECIP255, DEST_RESULT, 1'b1, 2'd0};
         default: word = '{OPA_CHAN, OPB_BRIGHT, DEST_PROD,  1'b0, 2'd0};
      endcase
      return word;
   endfunction

endpackage

// File: hw/rtl/pbg_sequencer.sv
// ----------------------------------------------------------------------------
// pbg_sequencer
// Step counter, channel counter and control store decode.
// ----------------------------------------------------------------------------
module pbg_sequencer
   import pbg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    out_hold,
   output logic    busy,
   output ctl_type ctl
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type state_ff, state_in;
   pc_type pc_ff, pc_in;
   chan_type chan_ff, chan_in;
   ucode_word_type word;
   logic end_step;
   logic advance;
   logic running;

   assign word = ucode_rom(pc_ff);
   assign end_step = word.jump_chan && (chan_ff == CHAN_LAST);

   always_comb begin
      unique case (state_ff)
         ST_IDLE: running = 1'b0;
         ST_RUN:  running = 1'b1;
         default: running = 1'b0;
      endcase
   end

   // The final step waits while the previous result is still unclaimed.
   assign advance = running && !(end_step && out_hold);

   always_comb begin
      state_in = state_ff;
      pc_in = pc_ff;
      chan_in = chan_ff;
      if (!running) begin
         if (start) begin
            state_in = ST_RUN;
            pc_in = '0;
            chan_in = CHAN_RED;
         end
      end else if (advance) begin
         if (word.jump_chan) begin
            if (end_step) begin
               state_in = ST_IDLE;
               pc_in = '0;
            end else begin
               pc_in = word.target;
               chan_in = chan_ff + 2'd1;
            end
         end else begin
            pc_in = pc_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff <= '0;
         chan_ff <= CHAN_RED;
      end else begin
         state_ff <= state_in;
         pc_ff <= pc_in;
         chan_ff <= chan_in;
      end
   end

   assign busy = running;
   assign ctl = '{en: advance, opa: word.opa, opb: word.opb, dest: word.dest,
                  chan: chan_ff, finish: advance && end_step};

endmodule

// File: hw/rtl/pbg_datapath.sv
// ----------------------------------------------------------------------------
// pbg_datapath
// Pixel registers, shared multiplier and the product and result registers.
// ----------------------------------------------------------------------------
module pbg_datapath
   import pbg_pkg::*;
(
   input  logic                clock,
   input  logic                load,
   input  logic [CHAN_W-1:0]   red_in,
   input  logic [CHAN_W-1:0]   green_in,
   input  logic [CHAN_W-1:0]   blue_in,
   input  logic [BRIGHT_W-1:0] bright,
   input  ctl_type             ctl,
   output logic [CHAN_W-1:0]   red_out,
   output logic [CHAN_W-1:0]   green_out,
   output logic [CHAN_W-1:0]   blue_out
);

   logic [CHAN_W-1:0] pix_red_ff, pix_green_ff, pix_blue_ff;
   logic [CHAN_W-1:0] res_red_ff, res_green_ff;
   logic [31:0] prod_ff;
   logic [CHAN_W-1:0] chan_val;
   logic [CHAN_W-1:0] quot;
   logic [15:0] opa_val;
   logic [16:0] opb_val;
   logic [32:0] mul_w;
   logic [CHAN_W-1:0] curve_val;

   always_comb begin
      case (ctl.chan)
         CHAN_RED:   chan_val = pix_red_ff;
         CHAN_GREEN: chan_val = pix_green_ff;
         default:    chan_val = pix_blue_ff;
      endcase
   end

   // The scaled channel is the top of the product after the reciprocal step.
   assign quot = prod_ff[SHIFT_100 +: CHAN_W];

   always_comb begin
      unique case (ctl.opa)
         OPA_CHAN: opa_val = {8'd0, chan_val};
         OPA_PROD: opa_val = prod_ff[15:0];
         OPA_QUOT: opa_val = {8'd0, quot};
         default:  opa_val = prod_ff[15:0];
      endcase
   end

   always_comb begin
      unique case (ctl.opb)
         OPB_BRIGHT:   opb_val = {10'd0, bright};
         OPB_RECIP100: opb_val = RECIP_100;
         OPB_QUOT:     opb_val = {9'd0, quot};
         OPB_RECIP255: opb_val = RECIP_255;
         default:      opb_val = RECIP_255;
      endcase
   end

   assign mul_w = opa_val * opb_val;
   assign curve_val = mul_w[SHIFT_255 +: CHAN_W];

   always_ff @(posedge clock) begin
      if (load) begin
         pix_red_ff <= red_in;
         pix_green_ff <= green_in;
         pix_blue_ff <= blue_in;
      end
      if (ctl.en) begin
         if (ctl.dest == DEST_PROD) begin
            prod_ff <= mul_w[31:0];
         end else begin
            case (ctl.chan)
               CHAN_RED:   res_red_ff <= curve_val;
               CHAN_GREEN: res_green_ff <= curve_val;
               default:    ;
            endcase
         end
      end
   end

   assign red_out = res_red_ff;
   assign green_out = res_green_ff;
   assign blue_out = curve_val;

endmodule

// File: hw/rtl/pixel_brightness_gamma_pipeline_top.sv
// ----------------------------------------------------------------------------
// pixel_brightness_gamma_pipeline_top
// Brightness scaling and gamma 2.0 correction of RGB pixels for an LED frame.
// ----------------------------------------------------------------------------
// The block cannot take a new item until it is through with the last one:
// four microcode steps per colour channel run in turn on the single shared
// multiplier, and a stalled result holds the final step until the output
// register is free.
// Reset is synchronous and active high: brightness returns to 30 percent,
// the lit flag clears and the sequencer goes idle with no result pending.
// ----------------------------------------------------------------------------
module pixel_brightness_gamma_pipeline_top
   import pbg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_red_in,
   input  logic [7:0]          req_green_in,
   input  logic [7:0]          req_blue_in,
   input  logic                req_frame_last,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_red_out,
   output logic [7:0]          rsp_green_out,
   output logic [7:0]          rsp_blue_out,
   output logic                rsp_frame_done,
   output logic                rsp_strip_power,
   input  logic                csr_write_enable,
   input  logic [6:0]          csr_write_data
);

   logic accept;
   logic busy;
   ctl_type ctl;
   logic [CHAN_W-1:0] dp_red, dp_green, dp_blue;

   logic [BRIGHT_W-1:0] bright_ff;
   logic any_lit_ff, any_lit_in;
   logic lit;
   logic last_ff;
   logic power_ff;

   logic rsp_valid_ff;
   logic [CHAN_W-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic rsp_done_ff, rsp_power_ff;

   // The block takes a new item only while the sequencer is idle. The
   // output register lets an item start while the last result waits.
   assign req_stall = busy;
   assign accept = req_valid && !req_stall;

   // Brightness writes above the maximum are stored as the maximum.
   always_ff @(posedge clock) begin
      if (reset) begin
         bright_ff <= BRIGHT_RESET;
      end else if (csr_write_enable) begin
         bright_ff <= (csr_write_data > BRIGHT_MAX) ? BRIGHT_MAX : csr_write_data;
      end
   end

   // The lit flag gathers any nonzero raw channel across the frame. Its
   // verdict is taken when the item is accepted, and it is cleared by the
   // frame's last pixel so that the next frame starts fresh.
   assign lit = any_lit_ff || (req_red_in != 8'd0) || (req_green_in != 8'd0)
                || (req_blue_in != 8'd0);
   assign any_lit_in = req_frame_last ? 1'b0 : lit;

   always_ff @(posedge clock) begin
      if (reset) begin
         any_lit_ff <= 1'b0;
      end else if (accept) begin
         any_lit_ff <= any_lit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         last_ff <= req_frame_last;
         power_ff <= req_frame_last && lit;
      end
   end

   pbg_sequencer u_sequencer (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .out_hold (rsp_valid_ff && rsp_stall),
      .busy     (busy),
      .ctl      (ctl)
   );

   pbg_datapath u_datapath (
      .clock     (clock),
      .load      (accept),
      .red_in    (req_red_in),
      .green_in  (req_green_in),
      .blue_in   (req_blue_in),
      .bright    (bright_ff),
      .ctl       (ctl),
      .red_out   (dp_red),
      .green_out (dp_green),
      .blue_out  (dp_blue)
   );

   // The final step only fires when this register is empty or being taken,
   // so loading it always wins over clearing it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         rsp_red_ff <= dp_red;
         rsp_green_ff <= dp_green;
         rsp_blue_ff <= dp_blue;
         rsp_done_ff <= last_ff;
         rsp_power_ff <= power_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red_out = rsp_red_ff;
   assign rsp_green_out = rsp_green_ff;
   assign rsp_blue_out = rsp_blue_ff;
   assign rsp_frame_done = rsp_done_ff;
   assign rsp_strip_power = rsp_power_ff;

`ifndef SYNTH
   // An accepted item keeps the block busy until its result is produced.
   assert property (@(posedge clock) disable iff (reset) accept |=> req_stall)
      else $error("block not busy after accepting an item");

   // A finished item always shows up on the result channel.
   assert property (@(posedge clock) disable iff (reset) ctl.finish |=> rsp_valid)
      else $error("finished item not presented");

   // The final step never overwrites a result that is still stalled.
   assert property (@(posedge clock) disable iff (reset)
      ctl.finish |-> !(rsp_valid_ff && rsp_stall))
      else $error("pending result overwritten");

   // The last pixel of a frame leaves the lit flag clear.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_frame_last) |=> !any_lit_ff)
      else $error("lit flag not cleared at frame end");
`endif

endmodule

// File: tb/pixel_brightness_gamma_pipeline_top_test.sv
// ----------------------------------------------------------------------------
// pixel_brightness_gamma_pipeline_top_test
// Self-checking testbench for the brightness and gamma 2.0 pixel block. Every
// accepted pixel is passed through an integer predictor of the scaling, the
// gamma curve and the per-frame power flag. Each returned pixel is then
// compared field by field, in order, against the oldest prediction. The run
// steps through several brightness settings and several idling patterns, and
// includes one long output hold that backs the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pixel_brightness_gamma_pipeline_top_test
   import pbg_pkg::*;
();

   // Full-scale channel value; the gamma curve divides by this.
   localparam int unsigned CHAN_FULL = (1 << CHAN_W) - 1;
   // Cycles with no item moved on either channel before the run is declared hung.
   // This is well above the long output hold used in the back-pressure phase.
   localparam int unsigned WATCHDOG_LIMIT = 3000;
   // Cycles the output is held off while the sender keeps offering items.
   localparam int unsigned LONG_HOLD = 300;
   // Settling pause after the last result.
   localparam int unsigned SETTLE_CYCLES = 16;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              frame_last;
   } pixel_in_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              frame_done;
      logic              strip_power;
   } pixel_out_type;

   // The predictor keeps its own copy of the brightness register and of the
   // lit flag. It also holds the queue of pixels still owed by the block.
   class pixel_gamma_checker;
      logic [BRIGHT_W-1:0] brightness;
      logic                frame_lit;
      pixel_out_type       expected_pixels[$];
      int unsigned         error_count;

      function new();
         brightness = BRIGHT_RESET;
         frame_lit = 1'b0;
         error_count = 0;
      endfunction

      // Writes above the top of the range are stored as the top of the range.
      function void take_brightness(logic [BRIGHT_W-1:0] value);
         brightness = (value > BRIGHT_MAX) ? BRIGHT_MAX : value;
      endfunction

      function logic [CHAN_W-1:0] gamma_of(logic [CHAN_W-1:0] raw);
         int unsigned scaled;
         scaled = (32'(raw) * 32'(brightness)) / 32'(BRIGHT_MAX);
         return CHAN_W'((scaled * scaled) / CHAN_FULL);
      endfunction

      function void note_pixel(pixel_in_type px);
         pixel_out_type want;
         logic          lit;
         lit = frame_lit || (px.red != 0) || (px.green != 0) || (px.blue != 0);
         want.red = gamma_of(px.red);
         want.green = gamma_of(px.green);
         want.blue = gamma_of(px.blue);
         want.frame_done = px.frame_last;
         want.strip_power = px.frame_last && lit;
         frame_lit = px.frame_last ? 1'b0 : lit;
         expected_pixels.push_back(want);
      endfunction

      function int unsigned pending();
         return expected_pixels.size();
      endfunction

      task report_mismatch(string what, int unsigned got, int unsigned want);
         $display("%0t mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
         error_count++;
      endtask

      task check_pixel(pixel_out_type got);
         pixel_out_type want;
         if (expected_pixels.size() == 0) begin
            report_mismatch("result with no pixel outstanding", got, 0);
            return;
         end
         want = expected_pixels.pop_front();
         if (got.red != want.red) report_mismatch("red_out", got.red, want.red);
         if (got.green != want.green) report_mismatch("green_out", got.green, want.green);
         if (got.blue != want.blue) report_mismatch("blue_out", got.blue, want.blue);
         if (got.frame_done != want.frame_done)
            report_mismatch("frame_done", got.frame_done, want.frame_done);
         if (got.strip_power != want.strip_power)
            report_mismatch("strip_power", got.strip_power, want.strip_power);
      endtask
   endclass

   // Every input of the block starts at a known value.
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [CHAN_W-1:0] req_red_in = '0;
   logic [CHAN_W-1:0] req_green_in = '0;
   logic [CHAN_W-1:0] req_blue_in = '0;
   logic              req_frame_last = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [CHAN_W-1:0] rsp_red_out;
   logic [CHAN_W-1:0] rsp_green_out;
   logic [CHAN_W-1:0] rsp_blue_out;
   logic              rsp_frame_done;
   logic              rsp_strip_power;
   logic              csr_write_enable = 1'b0;
   logic [BRIGHT_W-1:0] csr_write_data = '0;

   // Idling pattern of the current phase, in percent of cycles.
   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   // Remaining cycles of a forced output hold. It is counted down by the
   // stall process itself.
   int unsigned stall_hold_left = 0;
   int unsigned quiet_cycles = 0;

   pixel_gamma_checker gamma_pred = new();

   pixel_brightness_gamma_pipeline_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_red_in       (req_red_in),
      .req_green_in     (req_green_in),
      .req_blue_in      (req_blue_in),
      .req_frame_last   (req_frame_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_strip_power  (rsp_strip_power),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // The receiver decides its stall on the falling edge, so the value is
   // settled well before the rising edge at which the block samples it.
   // A forced hold takes priority over the random pattern.
   always @(negedge clock) begin
      if (stall_hold_left > 0) begin
         rsp_stall <= 1'b1;
         stall_hold_left = stall_hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // Both channels are observed on the rising edge. Every input item that
   // the block takes yields exactly one prediction. Every result that it
   // hands over is checked against the oldest prediction still waiting.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         gamma_pred.note_pixel('{req_red_in, req_green_in, req_blue_in, req_frame_last});
      if (!reset && rsp_valid && !rsp_stall)
         gamma_pred.check_pixel('{rsp_red_out, rsp_green_out, rsp_blue_out,
                                  rsp_frame_done, rsp_strip_power});
   end

   // Any cycle in which neither channel moves an item counts towards the
   // hang limit. A healthy run never comes close to it.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("pixel_brightness_gamma_pipeline_top_test: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one pixel, after an optional random idle gap, and returns at the
   // rising edge where the block takes it. Valid is left high on purpose.
   // The next call either replaces the payload at once or drops valid for
   // its gap, so valid is never lowered and raised within one time step.
   task automatic send_pixel(pixel_in_type px);
      int unsigned gap;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < sender_idle_pct)
         gap++;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_red_in <= px.red;
      req_green_in <= px.green;
      req_blue_in <= px.blue;
      req_frame_last <= px.frame_last;
      do
         @(posedge clock);
      while (!(req_valid && !req_stall));
   endtask

   task automatic send_rgb(logic [CHAN_W-1:0] red, logic [CHAN_W-1:0] green,
                           logic [CHAN_W-1:0] blue, logic last);
      send_pixel('{red, green, blue, last});
   endtask

   // Drops valid on the falling edge right after the last accepted pixel.
   // This keeps the block from seeing the same payload twice.
   task automatic stop_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Waits until every predicted pixel has come back, then lets the pipeline
   // settle so that a register write cannot land on work still in flight.
   task automatic drain_pipeline();
      while (gamma_pred.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register writes are only issued while the block is idle. The predictor
   // takes the new value at the same moment.
   task automatic write_brightness(logic [BRIGHT_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      gamma_pred.take_brightness(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Random pixels are biased so that the interesting cases come up often.
   // About a fifth are fully black, which builds all-black frames. Single
   // channels often sit at zero or full scale. Frames average about six
   // pixels.
   function automatic pixel_in_type random_pixel();
      pixel_in_type px;
      logic [CHAN_W-1:0] chan [3];
      for (int i = 0; i < 3; i++) begin
         case ($urandom_range(7))
            0: chan[i] = '0;
            1: chan[i] = '1;
            default: chan[i] = CHAN_W'($urandom_range(CHAN_FULL));
         endcase
      end
      if ($urandom_range(9) < 2) begin
         chan[0] = '0;
         chan[1] = '0;
         chan[2] = '0;
      end
      px.red = chan[0];
      px.green = chan[1];
      px.blue = chan[2];
      px.frame_last = ($urandom_range(5) == 0);
      return px;
   endfunction

   task automatic run_random_phase(int unsigned count, int unsigned idle_pct,
                                   int unsigned stall_pct);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (count) send_pixel(random_pixel());
      stop_sending();
      drain_pipeline();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed pixels at the reset brightness first, so the reset value of
      // the register is exercised before anything overwrites it.
      send_rgb(8'd255, 8'd0, 8'd0, 1'b1);
      // A single-pixel black frame and a longer black frame both leave the
      // strip powered off.
      send_rgb(8'd0, 8'd0, 8'd0, 1'b1);
      send_rgb(8'd0, 8'd0, 8'd0, 1'b0);
      send_rgb(8'd0, 8'd0, 8'd0, 1'b0);
      send_rgb(8'd0, 8'd0, 8'd0, 1'b1);
      // A lit pixel early in a frame must still power the strip at its end.
      send_rgb(8'd0, 8'd1, 8'd0, 1'b0);
      send_rgb(8'd0, 8'd0, 8'd0, 1'b1);
      // The flag must have been cleared by the previous frame end.
      send_rgb(8'd0, 8'd0, 8'd0, 1'b1);
      send_rgb(8'd128, 8'd64, 8'd32, 1'b0);
      send_rgb(8'd255, 8'd255, 8'd255, 1'b1);
      stop_sending();
      drain_pipeline();

      // The largest write value saturates to full brightness.
      write_brightness(7'd127);
      send_rgb(8'd255, 8'd255, 8'd255, 1'b1);
      send_rgb(8'd1, 8'd1, 8'd1, 1'b1);
      send_rgb(8'd99, 8'd100, 8'd101, 1'b0);
      send_rgb(8'd170, 8'd85, 8'd254, 1'b1);
      stop_sending();
      drain_pipeline();

      // At zero brightness every channel is dark, yet any nonzero raw pixel
      // still powers the strip.
      write_brightness(7'd0);
      send_rgb(8'd255, 8'd128, 8'd7, 1'b1);
      send_rgb(8'd0, 8'd0, 8'd0, 1'b1);
      stop_sending();
      drain_pipeline();

      // Just above the range, the bottom of the nonzero range and the top.
      write_brightness(7'd101);
      send_rgb(8'd200, 8'd16, 8'd255, 1'b1);
      stop_sending();
      drain_pipeline();
      write_brightness(7'd1);
      send_rgb(8'd255, 8'd2, 8'd127, 1'b1);
      stop_sending();
      drain_pipeline();
      write_brightness(BRIGHT_MAX);
      send_rgb(8'd254, 8'd15, 8'd240, 1'b1);
      stop_sending();
      drain_pipeline();

      // Random phases, one per idling pattern. A fresh brightness is written
      // between them.
      run_random_phase(180, 0, 0);
      write_brightness(BRIGHT_W'($urandom_range(127)));
      run_random_phase(180, 59, 0);
      write_brightness(BRIGHT_W'($urandom_range(127)));
      run_random_phase(180, 0, 59);
      write_brightness(BRIGHT_W'($urandom_range(BRIGHT_MAX)));
      run_random_phase(180, 12, 12);

      // Back-pressure: the output is held off for a long stretch while the
      // sender keeps offering pixels. The block fills and must stall its
      // input without losing or reordering anything.
      write_brightness(BRIGHT_W'($urandom_range(BRIGHT_MAX)));
      stall_hold_left = LONG_HOLD;
      run_random_phase(30, 0, 0);

      if (gamma_pred.pending() != 0)
         gamma_pred.report_mismatch("pixels never returned", 0, gamma_pred.pending());
      if (gamma_pred.error_count == 0) begin
         $display("pixel_brightness_gamma_pipeline_top_test: PASS");
      end else begin
         $display("pixel_brightness_gamma_pipeline_top_test: FAIL");
      end
      $finish;
   end

endmodule
